// ----- sv/kts_pkg.sv -----
// Package for the keyframe track sampler: widths, register indexes, opcodes,
// reset values and the request/response types of the shared multiply-divide unit.
// No dependencies.
package kts_pkg;

  localparam int unsigned MAX_KEYS    = 64;
  localparam int unsigned KEY_AW      = $clog2(MAX_KEYS);
  localparam int unsigned KEY_IDX_W   = 6;
  localparam int unsigned TIME_W      = 24;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned VEC_W       = 3 * VAL_W;
  localparam int unsigned DT_W        = 16;
  localparam int unsigned FPS_W       = 8;
  localparam int unsigned RATE_W      = 9;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam int unsigned M1_W        = DT_W + FPS_W;
  localparam int unsigned M2_W        = M1_W + RATE_W;
  localparam int unsigned ADV_SHIFT   = 12;
  localparam int unsigned ADV_W       = M2_W - ADV_SHIFT;

  localparam int unsigned MD_AW       = VAL_W + 1;
  localparam int unsigned MD_BW       = TIME_W;
  localparam int unsigned MD_LO_W     = 16;
  localparam int unsigned MD_HI_W     = MD_AW - MD_LO_W;
  localparam int unsigned MD_PP_W     = MD_HI_W + MD_BW;
  localparam int unsigned MD_LOP_W    = MD_LO_W + MD_BW;
  localparam int unsigned MD_PROD_W   = MD_AW + MD_BW;
  localparam int unsigned DIV_STEPS   = MD_AW;
  localparam int unsigned MD_STEP_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYCNT  = 3'd6;

  localparam logic OP_KEY_WRITE = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  localparam logic [RATE_W-1:0] RATE_RESET   = 9'd256;
  localparam logic [FPS_W-1:0]  FPS_RESET    = 8'd30;
  localparam logic [CNT_W-1:0]  KEYCNT_RESET = 7'd2;
  localparam logic [CNT_W-1:0]  KEYCNT_MIN   = 7'd2;

  typedef struct packed {
    logic               start;
    logic [MD_AW-1:0]   mult_a;
    logic [MD_BW-1:0]   mult_b;
    logic [MD_BW-1:0]   divisor;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic [MD_AW-1:0]   quotient;
    logic [MD_BW-1:0]   remainder;
  } md_rsp_t;

endpackage

// ----- sv/kts_in_if.sv -----
// Request channel of the keyframe track sampler: valid/ready plus one key write
// or tick request. Depends on kts_pkg.
interface kts_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [kts_pkg::KEY_IDX_W-1:0]      key_index;
  logic [kts_pkg::TIME_W-1:0]         key_time;
  logic signed [kts_pkg::VAL_W-1:0]   key_x;
  logic signed [kts_pkg::VAL_W-1:0]   key_y;
  logic signed [kts_pkg::VAL_W-1:0]   key_z;
  logic [kts_pkg::DT_W-1:0]           delta_time;

  modport source (
    output valid, operation, key_index, key_time, key_x, key_y, key_z, delta_time,
    input  ready
  );
  modport sink (
    input  valid, operation, key_index, key_time, key_x, key_y, key_z, delta_time,
    output ready
  );
endinterface

// ----- sv/kts_out_if.sv -----
// Result channel of the keyframe track sampler: valid/ready plus one sampled
// value and playhead. Depends on kts_pkg.
interface kts_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [kts_pkg::VAL_W-1:0]   out_x;
  logic signed [kts_pkg::VAL_W-1:0]   out_y;
  logic signed [kts_pkg::VAL_W-1:0]   out_z;
  logic [kts_pkg::TIME_W-1:0]         playhead_out;
  logic                               at_end;

  modport source (
    output valid, out_x, out_y, out_z, playhead_out, at_end,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, playhead_out, at_end,
    output ready
  );
endinterface

// ----- sv/keyframe_track_sampler_unit.sv -----
// Keyframe track sampler: key store in two RAMs, playhead advance and wrap,
// bracketing-key search and per-component linear interpolation.
// A tick runs the playhead advance, a divide when it wraps with looping on, the key
// search and per-component interpolation divides (shared multiply-divide unit).
// Throughput: one request at a time; a result waiting at the output does not block input.
// Reset: config registers to defaults, playhead 0; key stores undefined until written.
module keyframe_track_sampler_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kts_in_if.sink                            in_i,
  kts_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [kts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kts_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MUL1     = 4'd1;
  localparam logic [3:0] ST_MUL2     = 4'd2;
  localparam logic [3:0] ST_ADV      = 4'd3;
  localparam logic [3:0] ST_WRAP     = 4'd4;
  localparam logic [3:0] ST_SR_RD    = 4'd5;
  localparam logic [3:0] ST_SR_CK    = 4'd6;
  localparam logic [3:0] ST_FT_CUR   = 4'd7;
  localparam logic [3:0] ST_FT_NXT   = 4'd8;
  localparam logic [3:0] ST_FT_END   = 4'd9;
  localparam logic [3:0] ST_DECIDE   = 4'd10;
  localparam logic [3:0] ST_IP_START = 4'd11;
  localparam logic [3:0] ST_IP_WAIT  = 4'd12;
  localparam logic [3:0] ST_OUT      = 4'd13;

  localparam logic [1:0] CMP_X = 2'd0;
  localparam logic [1:0] CMP_Y = 2'd1;
  localparam logic [1:0] CMP_Z = 2'd2;

  localparam int unsigned TW = kts_pkg::TIME_W;
  localparam int unsigned VW = kts_pkg::VAL_W;
  localparam int unsigned AW = kts_pkg::KEY_AW;

  // configuration
  logic                          playing_q, loop_q, reverse_q;
  logic [kts_pkg::RATE_W-1:0]    rate_q;
  logic [kts_pkg::FPS_W-1:0]     fps_q;
  logic [TW-1:0]                 len_q;
  logic [kts_pkg::CNT_W-1:0]     kcnt_q;

  logic [3:0]                    state_q, state_d;
  logic [TW-1:0]                 ph_q, ph_d;
  logic [kts_pkg::DT_W-1:0]      dt_q, dt_d;
  logic [kts_pkg::M1_W-1:0]      m1_q, m1_d;
  logic [kts_pkg::M2_W-1:0]      m2_q, m2_d;
  logic                          rev_wrap_q, rev_wrap_d;
  logic [AW-1:0]                 nxt_q, nxt_d;
  logic [TW-1:0]                 tc_q, tc_d, tn_q, tn_d;
  logic [kts_pkg::VEC_W-1:0]     va_q, va_d, vb_q, vb_d, res_q, res_d;
  logic [1:0]                    comp_q, comp_d;
  logic                          neg_q, neg_d;
  logic                          out_valid_q, out_valid_d;
  logic [kts_pkg::VEC_W-1:0]     out_vec_q, out_vec_d;
  logic [TW-1:0]                 out_ph_q, out_ph_d;
  logic                          out_end_q, out_end_d;

  logic                          in_acc;
  logic                          key_we;
  logic [AW-1:0]                 raddr;
  logic [TW-1:0]                 t_rdata;
  logic [kts_pkg::VEC_W-1:0]     v_rdata;
  kts_pkg::md_req_t              md_req;
  kts_pkg::md_rsp_t              md_rsp;

  logic [kts_pkg::ADV_W-1:0]     adv;
  logic [TW:0]                   fwd_p;
  logic                          fwd_over;
  logic                          rev_ok;
  logic [kts_pkg::CNT_W-1:0]     cnt_c;
  logic [AW-1:0]                 lim;
  logic [VW-1:0]                 va_c, vb_c, q32, ip_val;
  logic [VW:0]                   d33, mag;
  logic                          out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b1;
      loop_q    <= 1'b1;
      reverse_q <= 1'b0;
      rate_q    <= kts_pkg::RATE_RESET;
      fps_q     <= kts_pkg::FPS_RESET;
      len_q     <= '0;
      kcnt_q    <= kts_pkg::KEYCNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kts_pkg::CFG_PLAYING: playing_q <= cfg_wdata_i[0];
        kts_pkg::CFG_LOOP:    loop_q    <= cfg_wdata_i[0];
        kts_pkg::CFG_REVERSE: reverse_q <= cfg_wdata_i[0];
        kts_pkg::CFG_RATE:    rate_q    <= cfg_wdata_i[kts_pkg::RATE_W-1:0];
        kts_pkg::CFG_FPS:     fps_q     <= cfg_wdata_i[kts_pkg::FPS_W-1:0];
        kts_pkg::CFG_LENGTH:  len_q     <= cfg_wdata_i[TW-1:0];
        kts_pkg::CFG_KEYCNT:  kcnt_q    <= cfg_wdata_i[kts_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign key_we     = in_acc && (in_i.operation == kts_pkg::OP_KEY_WRITE);

  always_comb begin
    case (state_q)
      ST_FT_CUR: raddr = nxt_q - 1'b1;
      default:   raddr = nxt_q;
    endcase
  end

  kts_ram #(
    .WIDTH (TW),
    .DEPTH (kts_pkg::MAX_KEYS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (AW'(in_i.key_index)),
    .wdata_i (in_i.key_time),
    .raddr_i (raddr),
    .rdata_o (t_rdata)
  );

  kts_ram #(
    .WIDTH (kts_pkg::VEC_W),
    .DEPTH (kts_pkg::MAX_KEYS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (AW'(in_i.key_index)),
    .wdata_i ({in_i.key_z, in_i.key_y, in_i.key_x}),
    .raddr_i (raddr),
    .rdata_o (v_rdata)
  );

  kts_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  always_comb begin
    adv      = m2_q[kts_pkg::M2_W-1:kts_pkg::ADV_SHIFT];
    fwd_p    = {1'b0, ph_q} + (TW+1)'(adv);
    fwd_over = fwd_p > {1'b0, len_q};
    rev_ok   = TW'(adv) <= ph_q;

    if (kcnt_q < kts_pkg::KEYCNT_MIN) begin
      cnt_c = kts_pkg::KEYCNT_MIN;
    end else if (kcnt_q > kts_pkg::CNT_W'(kts_pkg::MAX_KEYS)) begin
      cnt_c = kts_pkg::CNT_W'(kts_pkg::MAX_KEYS);
    end else begin
      cnt_c = kcnt_q;
    end
    lim = AW'(cnt_c - 1'b1);

    case (comp_q)
      CMP_X: begin
        va_c = va_q[VW-1:0];
        vb_c = vb_q[VW-1:0];
      end
      CMP_Y: begin
        va_c = va_q[2*VW-1:VW];
        vb_c = vb_q[2*VW-1:VW];
      end
      default: begin
        va_c = va_q[3*VW-1:2*VW];
        vb_c = vb_q[3*VW-1:2*VW];
      end
    endcase
    d33    = {vb_c[VW-1], vb_c} - {va_c[VW-1], va_c};
    mag    = d33[VW] ? (~d33 + 1'b1) : d33;
    q32    = md_rsp.quotient[VW-1:0];
    ip_val = va_c + (neg_q ? (~q32 + 1'b1) : q32);
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    dt_d       = dt_q;
    m1_d       = m1_q;
    m2_d       = m2_q;
    rev_wrap_d = rev_wrap_q;
    nxt_d      = nxt_q;
    tc_d       = tc_q;
    tn_d       = tn_q;
    va_d       = va_q;
    vb_d       = vb_q;
    res_d      = res_q;
    comp_d     = comp_q;
    neg_d      = neg_q;
    out_vec_d  = out_vec_q;
    out_ph_d   = out_ph_q;
    out_end_d  = out_end_q;

    md_req.start   = 1'b0;
    md_req.mult_a  = mag;
    md_req.mult_b  = ph_q - tc_q;
    md_req.divisor = tn_q - tc_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.operation == kts_pkg::OP_TICK) && (len_q != '0)) begin
          dt_d    = in_i.delta_time;
          nxt_d   = AW'(1);
          state_d = playing_q ? ST_MUL1 : ST_SR_RD;
        end
      end
      ST_MUL1: begin
        m1_d    = kts_pkg::M1_W'(dt_q) * kts_pkg::M1_W'(fps_q);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        m2_d    = kts_pkg::M2_W'(m1_q) * kts_pkg::M2_W'(rate_q);
        state_d = ST_ADV;
      end
      ST_ADV: begin
        md_req.mult_b  = kts_pkg::MD_BW'(1);
        md_req.divisor = len_q;
        state_d        = ST_SR_RD;
        if (!reverse_q) begin
          md_req.mult_a = kts_pkg::MD_AW'(fwd_p - 1'b1);
          if (!fwd_over) begin
            ph_d = fwd_p[TW-1:0];
          end else if (loop_q) begin
            md_req.start = 1'b1;
            rev_wrap_d   = 1'b0;
            state_d      = ST_WRAP;
          end else begin
            ph_d = len_q;
          end
        end else begin
          md_req.mult_a = kts_pkg::MD_AW'(TW'(adv) - ph_q);
          if (rev_ok) begin
            ph_d = ph_q - TW'(adv);
          end else if (loop_q) begin
            md_req.start = 1'b1;
            rev_wrap_d   = 1'b1;
            state_d      = ST_WRAP;
          end else begin
            ph_d = '0;
          end
        end
      end
      ST_WRAP: begin
        if (md_rsp.done) begin
          if (!rev_wrap_q) begin
            ph_d = md_rsp.remainder + 1'b1;
          end else begin
            ph_d = (md_rsp.remainder != '0) ? (len_q - md_rsp.remainder) : '0;
          end
          state_d = ST_SR_RD;
        end
      end
      ST_SR_RD: begin
        state_d = ST_SR_CK;
      end
      ST_SR_CK: begin
        if ((nxt_q < lim) && (t_rdata < ph_q)) begin
          nxt_d   = nxt_q + 1'b1;
          state_d = ST_SR_RD;
        end else begin
          state_d = ST_FT_CUR;
        end
      end
      ST_FT_CUR: begin
        state_d = ST_FT_NXT;
      end
      ST_FT_NXT: begin
        tc_d    = t_rdata;
        va_d    = v_rdata;
        state_d = ST_FT_END;
      end
      ST_FT_END: begin
        tn_d    = t_rdata;
        vb_d    = v_rdata;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (ph_q <= tc_q) begin
          res_d   = va_q;
          state_d = ST_OUT;
        end else if (ph_q >= tn_q) begin
          res_d   = vb_q;
          state_d = ST_OUT;
        end else begin
          comp_d  = CMP_X;
          state_d = ST_IP_START;
        end
      end
      ST_IP_START: begin
        md_req.start = 1'b1;
        neg_d        = d33[VW];
        state_d      = ST_IP_WAIT;
      end
      ST_IP_WAIT: begin
        if (md_rsp.done) begin
          case (comp_q)
            CMP_X:   res_d[VW-1:0]      = ip_val;
            CMP_Y:   res_d[2*VW-1:VW]   = ip_val;
            default: res_d[3*VW-1:2*VW] = ip_val;
          endcase
          if (comp_q == CMP_Z) begin
            state_d = ST_OUT;
          end else begin
            comp_d  = comp_q + 1'b1;
            state_d = ST_IP_START;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_vec_d = res_q;
          out_ph_d  = ph_q;
          out_end_d = (ph_q == len_q);
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q       <= dt_d;
    m1_q       <= m1_d;
    m2_q       <= m2_d;
    rev_wrap_q <= rev_wrap_d;
    nxt_q      <= nxt_d;
    tc_q       <= tc_d;
    tn_q       <= tn_d;
    va_q       <= va_d;
    vb_q       <= vb_d;
    res_q      <= res_d;
    comp_q     <= comp_d;
    neg_q      <= neg_d;
    out_vec_q  <= out_vec_d;
    out_ph_q   <= out_ph_d;
    out_end_q  <= out_end_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_x        = out_vec_q[VW-1:0];
  assign out_o.out_y        = out_vec_q[2*VW-1:VW];
  assign out_o.out_z        = out_vec_q[3*VW-1:2*VW];
  assign out_o.playhead_out = out_ph_q;
  assign out_o.at_end       = out_end_q;

  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WRAP) && md_rsp.done) |=> (ph_q <= len_q))
    else $error("wrapped playhead beyond track length");

  a_md_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> ((state_q == ST_WRAP) || (state_q == ST_IP_WAIT)))
    else $error("divide result with no request waiting");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> ((nxt_q >= AW'(1)) && (nxt_q <= lim)))
    else $error("key search out of range");

  a_interp_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IP_START) |-> ((tc_q < ph_q) && (ph_q < tn_q)))
    else $error("interpolation outside bracketing keys");

endmodule

// ----- sv/kts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/kts_muldiv.sv -----
// Shared multiply-divide unit: quotient and remainder of (a * b) / d, with the
// product built from two partial products and a one-bit-per-cycle restoring divide.
// Depends on kts_pkg.
module kts_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kts_pkg::md_req_t  req_i,
  output kts_pkg::md_rsp_t  rsp_o
);

  localparam logic [2:0] MD_IDLE   = 3'd0;
  localparam logic [2:0] MD_MUL_LO = 3'd1;
  localparam logic [2:0] MD_MUL_HI = 3'd2;
  localparam logic [2:0] MD_ADD    = 3'd3;
  localparam logic [2:0] MD_DIV    = 3'd4;

  localparam logic [kts_pkg::MD_STEP_W-1:0] LAST_STEP =
    kts_pkg::MD_STEP_W'(kts_pkg::DIV_STEPS - 1);

  logic [2:0]                      state_q, state_d;
  logic [kts_pkg::MD_STEP_W-1:0]   step_q, step_d;
  logic                            done_q, done_d;
  logic [kts_pkg::MD_AW-1:0]       a_q, a_d;
  logic [kts_pkg::MD_BW-1:0]       b_q, b_d;
  logic [kts_pkg::MD_BW-1:0]       d_q, d_d;
  logic [kts_pkg::MD_LOP_W-1:0]    lo_q, lo_d;
  logic [kts_pkg::MD_PP_W-1:0]     hi_q, hi_d;
  logic [kts_pkg::MD_BW-1:0]       rem_q, rem_d;
  logic [kts_pkg::MD_AW-1:0]       dvd_q, dvd_d;

  logic [kts_pkg::MD_HI_W-1:0]     mul_a;
  logic [kts_pkg::MD_PP_W-1:0]     pp;
  logic [kts_pkg::MD_PROD_W-1:0]   prod;
  logic [kts_pkg::MD_BW:0]         trial;
  logic [kts_pkg::MD_BW:0]         diff;
  logic                            ge;

  always_comb begin
    mul_a = (state_q == MD_MUL_LO) ? kts_pkg::MD_HI_W'(a_q[kts_pkg::MD_LO_W-1:0])
                                   : a_q[kts_pkg::MD_AW-1:kts_pkg::MD_LO_W];
    pp    = kts_pkg::MD_PP_W'(mul_a) * kts_pkg::MD_PP_W'(b_q);
    prod  = {hi_q, {kts_pkg::MD_LO_W{1'b0}}} + kts_pkg::MD_PROD_W'(lo_q);
    trial = {rem_q, dvd_q[kts_pkg::MD_AW-1]};
    diff  = trial - {1'b0, d_q};
    ge    = (trial >= {1'b0, d_q});
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.mult_a;
          b_d     = req_i.mult_b;
          d_d     = req_i.divisor;
          state_d = MD_MUL_LO;
        end
      end
      MD_MUL_LO: begin
        lo_d    = pp[kts_pkg::MD_LOP_W-1:0];
        state_d = MD_MUL_HI;
      end
      MD_MUL_HI: begin
        hi_d    = pp;
        state_d = MD_ADD;
      end
      MD_ADD: begin
        rem_d   = prod[kts_pkg::MD_PROD_W-1:kts_pkg::MD_AW];
        dvd_d   = prod[kts_pkg::MD_AW-1:0];
        step_d  = '0;
        state_d = MD_DIV;
      end
      MD_DIV: begin
        rem_d = ge ? diff[kts_pkg::MD_BW-1:0] : trial[kts_pkg::MD_BW-1:0];
        dvd_d = {dvd_q[kts_pkg::MD_AW-2:0], ge};
        if (step_q == LAST_STEP) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    a_q    <= a_d;
    b_q    <= b_d;
    d_q    <= d_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MD_DIV) |-> (rem_q < d_q))
    else $error("partial remainder not below divisor");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held for more than one cycle");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == MD_IDLE))
    else $error("start while busy");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for keyframe_track_sampler_unit: a directed table, then
// random key tracks and ticks, checked against an in-bench track predictor, typed
// rows apart. Depends on kts_pkg, kts_in_if, kts_out_if and the sampler RTL.
`timescale 1ns / 1ps

module testbench;
  import kts_pkg::*;

  localparam int unsigned ITEM_TARGET     = 1200;
  localparam int unsigned WIND_DOWN       = 150;
  localparam int unsigned SETTLE_CYCLES   = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 1000;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic                 op;
    logic [KEY_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    t;
    logic [VAL_W-1:0]     x;
    logic [VAL_W-1:0]     y;
    logic [VAL_W-1:0]     z;
    logic [DT_W-1:0]      dt;
  } track_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
    logic [TIME_W-1:0] ph;
    logic              at_end;
  } track_sample_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_REQ_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    track_req_t            req;
    track_sample_t         typed;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kts_in_if  req_if();
  kts_out_if smp_if();

  keyframe_track_sampler_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (req_if),
    .out_o      (smp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // track predictor state
  logic [TIME_W-1:0] key_times [MAX_KEYS];
  logic [VAL_W-1:0]  key_vals  [MAX_KEYS][3];
  logic [TIME_W-1:0] playhead_q = '0;
  logic              play_en    = 1'b1;
  logic              loop_en    = 1'b1;
  logic              rev_en     = 1'b0;
  logic [RATE_W-1:0] rate_q     = RATE_RESET;
  logic [FPS_W-1:0]  fps_q      = FPS_RESET;
  logic [TIME_W-1:0] len_q      = '0;
  logic [CNT_W-1:0]  cnt_q      = KEYCNT_RESET;

  track_sample_t expected_samples[$];
  int unsigned   sample_errors = 0;
  int unsigned   items_sent    = 0;
  int unsigned   quiet_cycles  = 0;
  bit            pending_work  = 1'b0;
  bit            sender_gaps   = 1'b1;
  bit            sink_stalls   = 1'b1;
  bit            hold_off_req  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PLAYING: play_en = data[0];
      CFG_LOOP:    loop_en = data[0];
      CFG_REVERSE: rev_en  = data[0];
      CFG_RATE:    rate_q  = data[RATE_W-1:0];
      CFG_FPS:     fps_q   = data[FPS_W-1:0];
      CFG_LENGTH:  len_q   = data[TIME_W-1:0];
      CFG_KEYCNT:  cnt_q   = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit step_track(input track_req_t r, output track_sample_t s);
    longint unsigned adv, p, rem;
    int unsigned     cnt, nxt, cur, c;
    longint          pl, tc, tn, a, b, v;
    logic [VAL_W-1:0] comp [3];
    s = '0;
    if (r.op == OP_KEY_WRITE) begin
      key_times[r.idx]   = r.t;
      key_vals[r.idx][0] = r.x;
      key_vals[r.idx][1] = r.y;
      key_vals[r.idx][2] = r.z;
      return 1'b0;
    end
    if (len_q == '0) return 1'b0;
    if (play_en) begin
      adv = (64'(r.dt) * 64'(fps_q) * 64'(rate_q)) >> ADV_SHIFT;
      if (!rev_en) begin
        p = 64'(playhead_q) + adv;
        if (p > 64'(len_q)) p = loop_en ? ((p - 1) % 64'(len_q)) + 1 : 64'(len_q);
        playhead_q = p[TIME_W-1:0];
      end else if (adv <= 64'(playhead_q)) begin
        playhead_q = playhead_q - adv[TIME_W-1:0];
      end else if (loop_en) begin
        rem = (adv - 64'(playhead_q)) % 64'(len_q);
        playhead_q = (rem != 0) ? len_q - rem[TIME_W-1:0] : '0;
      end else begin
        playhead_q = '0;
      end
    end
    cnt = cnt_q;
    if (cnt < 2) cnt = 2;
    if (cnt > MAX_KEYS) cnt = MAX_KEYS;
    nxt = 1;
    while (nxt < cnt - 1 && key_times[nxt] < playhead_q) nxt++;
    cur = nxt - 1;
    pl = 64'(playhead_q);
    tc = 64'(key_times[cur]);
    tn = 64'(key_times[nxt]);
    for (c = 0; c < 3; c++) begin
      a = signed'(key_vals[cur][c]);
      b = signed'(key_vals[nxt][c]);
      if (pl <= tc) v = a;
      else if (pl >= tn) v = b;
      else v = a + ((b - a) * (pl - tc)) / (tn - tc);
      comp[c] = v[VAL_W-1:0];
    end
    s.x      = comp[0];
    s.y      = comp[1];
    s.z      = comp[2];
    s.ph     = playhead_q;
    s.at_end = (playhead_q == len_q);
    return 1'b1;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind     = ROW_CFG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic stim_row_t key_row(input logic [KEY_IDX_W-1:0] idx,
                                        input logic [TIME_W-1:0] t,
                                        input logic [VAL_W-1:0] x, y, z);
    stim_row_t row;
    row = '0;
    row.kind   = ROW_REQ;
    row.req.op = OP_KEY_WRITE;
    row.req.idx = idx;
    row.req.t  = t;
    row.req.x  = x;
    row.req.y  = y;
    row.req.z  = z;
    return row;
  endfunction

  function automatic stim_row_t tick_row(input logic [DT_W-1:0] dt);
    stim_row_t row;
    row = '0;
    row.kind   = ROW_REQ;
    row.req.op = OP_TICK;
    row.req.dt = dt;
    return row;
  endfunction

  function automatic stim_row_t typed_tick(input logic [DT_W-1:0] dt,
                                           input logic [VAL_W-1:0] x, y, z,
                                           input logic [TIME_W-1:0] ph,
                                           input logic at_end);
    stim_row_t row;
    row = tick_row(dt);
    row.kind  = ROW_REQ_TYPED;
    row.typed = '{x: x, y: y, z: z, ph: ph, at_end: at_end};
    return row;
  endfunction

  // drop valid, wait for every pending sample, then let the block go quiet
  task automatic settle();
    if (pending_work) begin
      req_if.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      pending_work = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic send_request(input track_req_t r, input bit typed_on,
                              input track_sample_t typed);
    track_sample_t s;
    bit            produced;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= r.op;
    req_if.key_index  <= r.idx;
    req_if.key_time   <= r.t;
    req_if.key_x      <= r.x;
    req_if.key_y      <= r.y;
    req_if.key_z      <= r.z;
    req_if.delta_time <= r.dt;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_work = 1'b1;
    produced = step_track(r, s);
    if (produced) expected_samples.push_back(typed_on ? typed : s);
    if (produced || r.op == OP_KEY_WRITE) items_sent++;
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin : sample_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    smp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        smp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        smp_if.ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        smp_if.ready <= 1'b0;
      end else begin
        smp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : sample_check
    track_sample_t got;
    track_sample_t want;
    bit            have_want;
    if (smp_if.valid === 1'b1 && smp_if.ready === 1'b1) begin
      got.x      = smp_if.out_x;
      got.y      = smp_if.out_y;
      got.z      = smp_if.out_z;
      got.ph     = smp_if.playhead_out;
      got.at_end = smp_if.at_end;
      have_want  = expected_samples.size() != 0;
      if (have_want) want = expected_samples.pop_front();
      else want = 'x;
      if (!have_want || got !== want) begin
        sample_errors++;
        if (sample_errors <= 10)
          $display("sample mismatch%s: expected x=%h y=%h z=%h ph=%h end=%b, got x=%h y=%h z=%h ph=%h end=%b",
                   have_want ? "" : " (none pending)",
                   want.x, want.y, want.z, want.ph, want.at_end,
                   got.x, got.y, got.z, got.ph, got.at_end);
      end
    end
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (smp_if.valid === 1'b1 && smp_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t       opening_rows[$];
    track_req_t      r;
    int unsigned     scene, k, n_keys, n_ticks, span;
    longint unsigned t_acc;
    logic [TIME_W-1:0] len_pick;
    bit              scrambled, pressure, winding_down;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_wdata            <= '0;
    req_if.valid         <= 1'b0;
    req_if.operation     <= OP_KEY_WRITE;
    req_if.key_index     <= '0;
    req_if.key_time      <= '0;
    req_if.key_x         <= '0;
    req_if.key_y         <= '0;
    req_if.key_z         <= '0;
    req_if.delta_time    <= '0;

    opening_rows.push_back(tick_row(16'hFFFF));
    opening_rows.push_back(key_row(0, 24'h000000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    opening_rows.push_back(key_row(1, 24'h001000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'hFFFF_FFFF));
    opening_rows.push_back(cfg_row(CFG_LENGTH, 24'h001000));
    opening_rows.push_back(typed_tick(16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                      24'h000000, 1'b0));
    opening_rows.push_back(tick_row(16'h0800));
    opening_rows.push_back(tick_row(16'hFFFF));
    opening_rows.push_back(cfg_row(CFG_LOOP, 24'd0));
    opening_rows.push_back(typed_tick(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'hFFFF_FFFF, 24'h001000, 1'b1));
    opening_rows.push_back(cfg_row(CFG_REVERSE, 24'd1));
    opening_rows.push_back(typed_tick(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                      24'h000000, 1'b0));
    opening_rows.push_back(cfg_row(CFG_PLAYING, 24'd0));
    opening_rows.push_back(typed_tick(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                      24'h000000, 1'b0));
    opening_rows.push_back(cfg_row(CFG_PLAYING, 24'd1));
    opening_rows.push_back(cfg_row(CFG_LOOP, 24'd1));
    opening_rows.push_back(tick_row(16'h0123));
    opening_rows.push_back(cfg_row(CFG_KEYCNT, 24'd1));
    opening_rows.push_back(tick_row(16'h1000));
    opening_rows.push_back(cfg_row(CFG_RATE, 24'd0));
    opening_rows.push_back(cfg_row(CFG_FPS, 24'd240));
    opening_rows.push_back(tick_row(16'hFFFF));
    opening_rows.push_back(cfg_row(CFG_RATE, 24'd256));
    opening_rows.push_back(cfg_row(CFG_REVERSE, 24'd0));
    opening_rows.push_back(key_row(63, 24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'h1234_5678));
    opening_rows.push_back(key_row(1, 24'h000000, 32'h0001_0000, 32'hFFFF_0000,
                                   32'h7FFF_FFFF));
    opening_rows.push_back(tick_row(16'h0100));
    opening_rows.push_back(cfg_row(CFG_LENGTH, 24'hFFFFFF));
    opening_rows.push_back(key_row(1, 24'hFFFFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'h8000_0000));
    opening_rows.push_back(tick_row(16'hFFFF));
    opening_rows.push_back(tick_row(16'hFFFF));
    opening_rows.push_back(cfg_row(CFG_LENGTH, 24'h000800));
    opening_rows.push_back(cfg_row(CFG_REVERSE, 24'd1));
    opening_rows.push_back(tick_row(16'h0001));
    opening_rows.push_back(cfg_row(CFG_REVERSE, 24'd0));
    opening_rows.push_back(tick_row(16'h0001));
    opening_rows.push_back(cfg_row(CFG_LOOP, 24'd0));
    opening_rows.push_back(tick_row(16'h0001));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i]) begin
      case (opening_rows[i].kind)
        ROW_CFG: write_reg(opening_rows[i].reg_idx, opening_rows[i].reg_data);
        ROW_REQ: send_request(opening_rows[i].req, 1'b0, opening_rows[i].typed);
        default: send_request(opening_rows[i].req, 1'b1, opening_rows[i].typed);
      endcase
    end

    scene = 0;
    while (items_sent < ITEM_TARGET) begin
      winding_down = items_sent + WIND_DOWN > ITEM_TARGET;
      pressure     = (scene == 2);
      sender_gaps  = !winding_down && !pressure && ($urandom_range(0, 3) != 0);
      sink_stalls  = !winding_down && ($urandom_range(0, 3) != 0);

      // load a track; the first one fills every slot
      if (scene == 0) n_keys = MAX_KEYS;
      else if ($urandom_range(0, 9) == 0) n_keys = $urandom_range(2, MAX_KEYS);
      else n_keys = $urandom_range(2, 8);
      case ($urandom_range(0, 3))
        0: span = $urandom_range(1, 32'h4000);
        1: span = $urandom_range(1, 32'h40000);
        2: span = $urandom_range(1, 32'hFFFFFF);
        default: span = 32'h1000 * n_keys;
      endcase
      scrambled = (scene != 0) && ($urandom_range(0, 9) == 0);
      t_acc = $urandom_range(0, span / 8);
      for (k = 0; k < n_keys; k++) begin
        r     = '0;
        r.op  = OP_KEY_WRITE;
        r.idx = k;
        r.dt  = $urandom;
        r.x   = pick_value();
        r.y   = pick_value();
        r.z   = pick_value();
        if (scrambled) begin
          r.t = $urandom;
        end else begin
          r.t = (t_acc > 64'hFFFFFF) ? 24'hFFFFFF : t_acc[TIME_W-1:0];
          t_acc += $urandom_range(0, 2 * span / n_keys);
        end
        send_request(r, 1'b0, '0);
      end

      case ($urandom_range(0, 19))
        0: len_pick = '0;
        1, 2: len_pick = $urandom;
        default: len_pick = (t_acc > 64'hFFFFFF) ? 24'hFFFFFF : t_acc[TIME_W-1:0];
      endcase
      if (scrambled) len_pick = $urandom;
      if (pressure && len_pick == '0) len_pick = 24'h001000;

      write_reg(CFG_PLAYING, ($urandom_range(0, 9) != 0));
      write_reg(CFG_LOOP, $urandom_range(0, 1));
      write_reg(CFG_REVERSE, ($urandom_range(0, 3) == 0));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_RATE, 24'd0);
        1: write_reg(CFG_RATE, 24'd256);
        default: write_reg(CFG_RATE, $urandom_range(0, 256));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_FPS, 24'd1);
        1: write_reg(CFG_FPS, 24'd240);
        default: write_reg(CFG_FPS, $urandom_range(1, 240));
      endcase
      write_reg(CFG_LENGTH, len_pick);
      if ($urandom_range(0, 9) != 0) write_reg(CFG_KEYCNT, n_keys);
      else if ($urandom_range(0, 1) != 0) write_reg(CFG_KEYCNT, $urandom_range(0, 1));
      else write_reg(CFG_KEYCNT, $urandom_range(MAX_KEYS + 1, 127));

      n_ticks = pressure ? 40 : $urandom_range(8, 30);
      if (pressure) hold_off_req = 1'b1;
      for (k = 0; k < n_ticks; k++) begin
        if (k == n_ticks / 2 && !pressure && $urandom_range(0, 1) != 0) begin
          case ($urandom_range(0, 3))
            0: write_reg(CFG_LENGTH, (len_q >> $urandom_range(1, 4)) | 24'd1);
            1: write_reg(CFG_REVERSE, !rev_en);
            2: write_reg(CFG_LOOP, !loop_en);
            default: write_reg(CFG_PLAYING, !play_en);
          endcase
        end
        r     = '0;
        r.idx = $urandom;
        r.t   = $urandom;
        r.x   = $urandom;
        r.y   = $urandom;
        r.z   = $urandom;
        if ($urandom_range(0, 11) == 0) begin
          r.op = OP_KEY_WRITE;
        end else begin
          r.op = OP_TICK;
          r.dt = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 2048);
        end
        send_request(r, 1'b0, '0);
      end
      scene++;
    end

    pending_work = 1'b1;
    settle();
    if (sample_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/kts_pkg.sv
sv/kts_in_if.sv
sv/kts_out_if.sv
sv/kts_ram.sv
sv/kts_muldiv.sv
sv/keyframe_track_sampler_unit.sv
test/testbench.sv
